// File: rtl/sh2dl_pkg.sv
// types, constants and shared arithmetic for the order-2 sh light accumulator
package sh2dl_pkg;

    localparam int NUM_COEF = 9;
    localparam int IDX_W    = 4;
    localparam int DIR_W    = 16;
    localparam int COL_W    = 16;
    localparam int P_W      = 32;
    localparam int M_W      = 34;
    localparam int K_W      = 17;
    localparam int BP_W     = M_W + K_W;
    localparam int B_W      = 36;
    localparam int CP_W     = COL_W + 1 + B_W;
    localparam int R_W      = CP_W - 24;
    localparam int OUT_W    = 32;
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 104;

    typedef logic [IDX_W-1:0] coef_idx_t;

    localparam coef_idx_t IDX_DC   = 4'd0;
    localparam coef_idx_t IDX_Y    = 4'd1;
    localparam coef_idx_t IDX_Z    = 4'd2;
    localparam coef_idx_t IDX_X    = 4'd3;
    localparam coef_idx_t IDX_XY   = 4'd4;
    localparam coef_idx_t IDX_ZY   = 4'd5;
    localparam coef_idx_t IDX_ZZ   = 4'd6;
    localparam coef_idx_t IDX_XZ   = 4'd7;
    localparam coef_idx_t IDX_XXYY = 4'd8;
    localparam coef_idx_t IDX_LAST = IDX_XXYY;

    // basis constants, unsigned q2.14
    localparam logic [15:0] K_C0 = 16'd13666;
    localparam logic [15:0] K_C1 = 16'd23670;
    localparam logic [15:0] K_C2 = 16'd52928;
    localparam logic [15:0] K_C3 = 16'd15279;
    localparam logic [15:0] K_C4 = 16'd26464;

    localparam logic signed [B_W-1:0]  BASIS_DC  = 36'sd223903744;
    localparam logic signed [M_W-1:0]  ONE_Q28   = 34'sd268435456;
    localparam logic signed [BP_W-1:0] RND_B     = 51'sd8192;
    localparam logic signed [CP_W-1:0] RND_C     = 53'sd8388608;

    typedef enum logic
    {
        ST_IDLE,
        ST_RUN
    } sh2dl_state_t;

    typedef struct packed
    {
        logic      load;
        logic      issue;
        coef_idx_t index;
    } sh2dl_cmd_t;

    typedef struct packed
    {
        logic adv;
    } sh2dl_sts_t;

    // color times basis, rounded half up from q.40 to q.16
    function automatic logic signed [R_W-1:0] scale_col
    (
        input logic [COL_W-1:0]       col,
        input logic signed [B_W-1:0]  basis
    );
        logic signed [CP_W-1:0] p;
        p = $signed({1'b0, col}) * basis;
        p = p + RND_C;
        return p[CP_W-1:24];
    endfunction

endpackage

// File: rtl/sh_order2_directional_light_accumulate.sv
// top level: order-2 spherical-harmonic projection of directional lights
//
// slave channel takes one directional light per beat: a q1.14 unit direction and
// an unsigned q4.12 rgb color. for every light the block adds color times the
// nine scaled basis values into 27 saturating accumulators and sends nine beats on
// the master channel, one per coefficient index 0..8, with tlast on index 8.
// each master beat carries the accumulator triple after this light, clipped to
// signed 32-bit q16.16.
// the first result passes stages a, b, c and the output register after the light is
// accepted; the other eight follow one per cycle, unless the receiver stalls, through
// the four-stage basis/multiply pipeline. lights go through the single shared multiply
// and accumulate path that handles one coefficient index per cycle when not stalled;
// the next light is taken in the cycle that issues index 8.
// reset clears all accumulators to zero and empties the pipeline.
// when the receiver stalls, the output register holds its beat and the whole
// pipeline and index counter freeze; no beat is lost or repeated.
module sh_order2_directional_light_accumulate
#(
    parameter int ACC_WIDTH = 32
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // dir_x, dir_y, dir_z, red_in, green_in, blue_in
    input  logic [sh2dl_pkg::IN_DATA_W-1:0]       s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // coeff_index, red_coeff, green_coeff, blue_coeff, zero fill
    output logic [sh2dl_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic                                  m_tlast
);

    sh2dl_pkg::sh2dl_cmd_t cmd;
    sh2dl_pkg::sh2dl_sts_t sts;

    sh2dl_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sh2dl_dpath
    #(
        .ACC_WIDTH (ACC_WIDTH)
    )
    u_dpath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .in_data  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// File: rtl/sh2dl_ctrl.sv
// controller: accepts lights and issues the nine coefficient indexes
module sh2dl_ctrl
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  sh2dl_pkg::sh2dl_sts_t   sts,
    output sh2dl_pkg::sh2dl_cmd_t   cmd
);

    sh2dl_pkg::sh2dl_state_t state_reg;
    sh2dl_pkg::sh2dl_state_t state_next;
    sh2dl_pkg::coef_idx_t    k_reg;
    sh2dl_pkg::coef_idx_t    k_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sh2dl_pkg::ST_IDLE;
            k_reg     <= sh2dl_pkg::IDX_DC;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        case (state_reg)
            sh2dl_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = sh2dl_pkg::ST_RUN;
                    k_next     = sh2dl_pkg::IDX_DC;
                end
            end
            sh2dl_pkg::ST_RUN:
            begin
                if (sts.adv)
                begin
                    if (k_reg == sh2dl_pkg::IDX_LAST)
                    begin
                        k_next     = sh2dl_pkg::IDX_DC;
                        state_next = s_tvalid ? sh2dl_pkg::ST_RUN : sh2dl_pkg::ST_IDLE;
                    end
                    else
                    begin
                        k_next = k_reg + 4'd1;
                    end
                end
            end
            default:
            begin
                state_next = sh2dl_pkg::ST_IDLE;
                k_next     = sh2dl_pkg::IDX_DC;
            end
        endcase
    end

    always_comb
    begin
        s_tready  = 1'b0;
        cmd.load  = 1'b0;
        cmd.issue = 1'b0;
        cmd.index = k_reg;
        case (state_reg)
            sh2dl_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            sh2dl_pkg::ST_RUN:
            begin
                cmd.issue = 1'b1;
                s_tready  = sts.adv && (k_reg == sh2dl_pkg::IDX_LAST);
                cmd.load  = s_tready && s_tvalid;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/sh2dl_dpath.sv
// datapath: basis pipeline, color multipliers, saturating accumulators, output register
module sh2dl_dpath
#(
    parameter int ACC_WIDTH = 32
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  sh2dl_pkg::sh2dl_cmd_t                  cmd,
    output sh2dl_pkg::sh2dl_sts_t                  sts,
    input  logic [sh2dl_pkg::IN_DATA_W-1:0]        in_data,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [sh2dl_pkg::OUT_DATA_W-1:0]       m_tdata,
    output logic                                   m_tlast
);

    localparam int SW = ((ACC_WIDTH > sh2dl_pkg::R_W) ? ACC_WIDTH : sh2dl_pkg::R_W) + 1;
    localparam int OW = (ACC_WIDTH > sh2dl_pkg::OUT_W) ? ACC_WIDTH : sh2dl_pkg::OUT_W;
    localparam logic signed [SW-1:0] SAT_HI = $signed({{(SW-ACC_WIDTH+1){1'b0}},
                                                       {(ACC_WIDTH-1){1'b1}}});
    localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - 1;
    localparam logic signed [OW-1:0] O_HI = $signed({{(OW-31){1'b0}}, {31{1'b1}}});
    localparam logic signed [OW-1:0] O_LO = -O_HI - 1;

    localparam int DW = sh2dl_pkg::DIR_W;
    localparam int CW = sh2dl_pkg::COL_W;

    logic adv;

    // latched light
    logic signed [DW-1:0] x_reg, y_reg, z_reg;
    logic [3*CW-1:0]      col_reg;

    // stage a: direction products
    logic                           a_valid_reg;
    sh2dl_pkg::coef_idx_t           a_idx_reg;
    logic [3*CW-1:0]                a_col_reg;
    logic signed [sh2dl_pkg::P_W-1:0] a_prod_reg, a_prod_next;

    // stage b: basis values
    logic                           b_valid_reg;
    sh2dl_pkg::coef_idx_t           b_idx_reg;
    logic [3*CW-1:0]                b_col_reg;
    logic signed [sh2dl_pkg::B_W-1:0] b_basis_reg, b_basis_next;
    logic signed [sh2dl_pkg::M_W-1:0] m_op;
    logic signed [sh2dl_pkg::K_W-1:0] k_op;
    logic signed [sh2dl_pkg::BP_W-1:0] b_prod, b_signed, b_rnd;
    logic                              b_neg;

    // stage c: scaled color terms
    logic                           c_valid_reg;
    sh2dl_pkg::coef_idx_t           c_idx_reg;
    logic signed [sh2dl_pkg::R_W-1:0] c_term_reg [3];
    logic signed [sh2dl_pkg::R_W-1:0] c_term_next [3];

    // accumulators and output
    logic signed [ACC_WIDTH-1:0] acc_reg [3][sh2dl_pkg::NUM_COEF];
    logic signed [ACC_WIDTH-1:0] acc_next [3];
    logic                        out_valid_reg;
    sh2dl_pkg::coef_idx_t        out_idx_reg;
    logic                        out_last_reg;
    logic [sh2dl_pkg::OUT_W-1:0] out_coeff_reg [3];

    function automatic logic signed [ACC_WIDTH-1:0] acc_add
    (
        input logic signed [ACC_WIDTH-1:0]        a,
        input logic signed [sh2dl_pkg::R_W-1:0]   d
    );
        logic signed [SW-1:0] s;
        s = SW'(a) + SW'(d);
        if (s > SAT_HI)
            s = SAT_HI;
        else if (s < SAT_LO)
            s = SAT_LO;
        return s[ACC_WIDTH-1:0];
    endfunction

    function automatic logic [sh2dl_pkg::OUT_W-1:0] to_out
    (
        input logic signed [ACC_WIDTH-1:0] a
    );
        logic signed [OW-1:0] e;
        e = OW'(a);
        if (e > O_HI)
            e = O_HI;
        else if (e < O_LO)
            e = O_LO;
        return e[sh2dl_pkg::OUT_W-1:0];
    endfunction

    assign adv     = !out_valid_reg || m_tready;
    assign sts.adv = adv;

    // stage a
    always_comb
    begin
        case (cmd.index)
            sh2dl_pkg::IDX_Y:    a_prod_next = sh2dl_pkg::P_W'(y_reg);
            sh2dl_pkg::IDX_Z:    a_prod_next = sh2dl_pkg::P_W'(z_reg);
            sh2dl_pkg::IDX_X:    a_prod_next = sh2dl_pkg::P_W'(x_reg);
            sh2dl_pkg::IDX_XY:   a_prod_next = x_reg * y_reg;
            sh2dl_pkg::IDX_ZY:   a_prod_next = z_reg * y_reg;
            sh2dl_pkg::IDX_ZZ:   a_prod_next = z_reg * z_reg;
            sh2dl_pkg::IDX_XZ:   a_prod_next = x_reg * z_reg;
            sh2dl_pkg::IDX_XXYY: a_prod_next = (x_reg * x_reg) - (y_reg * y_reg);
            default:             a_prod_next = '0;
        endcase
    end

    // stage b
    always_comb
    begin
        if (a_idx_reg == sh2dl_pkg::IDX_ZZ)
            m_op = (sh2dl_pkg::M_W'(a_prod_reg) <<< 1) + sh2dl_pkg::M_W'(a_prod_reg)
                   - sh2dl_pkg::ONE_Q28;
        else
            m_op = sh2dl_pkg::M_W'(a_prod_reg);

        case (a_idx_reg)
            sh2dl_pkg::IDX_Y, sh2dl_pkg::IDX_Z, sh2dl_pkg::IDX_X:
                k_op = $signed({1'b0, sh2dl_pkg::K_C1});
            sh2dl_pkg::IDX_ZZ:
                k_op = $signed({1'b0, sh2dl_pkg::K_C3});
            sh2dl_pkg::IDX_XXYY:
                k_op = $signed({1'b0, sh2dl_pkg::K_C4});
            default:
                k_op = $signed({1'b0, sh2dl_pkg::K_C2});
        endcase

        b_neg = (a_idx_reg == sh2dl_pkg::IDX_Y) || (a_idx_reg == sh2dl_pkg::IDX_X) ||
                (a_idx_reg == sh2dl_pkg::IDX_ZY) || (a_idx_reg == sh2dl_pkg::IDX_XZ);

        b_prod   = m_op * k_op;
        b_signed = b_neg ? -b_prod : b_prod;
        b_rnd    = b_signed + sh2dl_pkg::RND_B;

        case (a_idx_reg)
            sh2dl_pkg::IDX_DC:
                b_basis_next = sh2dl_pkg::BASIS_DC;
            sh2dl_pkg::IDX_Y, sh2dl_pkg::IDX_Z, sh2dl_pkg::IDX_X:
                b_basis_next = sh2dl_pkg::B_W'(b_signed);
            default:
                b_basis_next = b_rnd[sh2dl_pkg::B_W+13:14];
        endcase
    end

    // stage c
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            c_term_next[ch] = sh2dl_pkg::scale_col(b_col_reg[ch*CW +: CW], b_basis_reg);
        end
    end

    // accumulate
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            acc_next[ch] = acc_add(acc_reg[ch][c_idx_reg], c_term_reg[ch]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int ch = 0; ch < 3; ch++)
            begin
                for (int i = 0; i < sh2dl_pkg::NUM_COEF; i++)
                begin
                    acc_reg[ch][i] <= '0;
                end
            end
        end
        else if (adv)
        begin
            a_valid_reg   <= cmd.issue;
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg;
            out_valid_reg <= c_valid_reg;
            if (c_valid_reg)
            begin
                for (int ch = 0; ch < 3; ch++)
                begin
                    acc_reg[ch][c_idx_reg] <= acc_next[ch];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg   <= in_data[15:0];
            y_reg   <= in_data[31:16];
            z_reg   <= in_data[47:32];
            col_reg <= in_data[95:48];
        end
        if (adv)
        begin
            a_idx_reg   <= cmd.index;
            a_col_reg   <= col_reg;
            a_prod_reg  <= a_prod_next;
            b_idx_reg   <= a_idx_reg;
            b_col_reg   <= a_col_reg;
            b_basis_reg <= b_basis_next;
            c_idx_reg   <= b_idx_reg;
            for (int ch = 0; ch < 3; ch++)
            begin
                c_term_reg[ch] <= c_term_next[ch];
            end
            if (c_valid_reg)
            begin
                out_idx_reg  <= c_idx_reg;
                out_last_reg <= (c_idx_reg == sh2dl_pkg::IDX_LAST);
                for (int ch = 0; ch < 3; ch++)
                begin
                    out_coeff_reg[ch] <= to_out(acc_next[ch]);
                end
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {4'b0000, out_coeff_reg[2], out_coeff_reg[1], out_coeff_reg[0],
                       out_idx_reg};

endmodule
